// File: rtl/mrh_pkg.sv
// ============================================================================
// mrh_pkg
// Types, constants and register indexes shared by the multiply-rotate hash.
// ============================================================================
package mrh_pkg;

	localparam logic [31:0] K01 = 32'h939b9659;
	localparam logic [31:0] K02 = 32'hab1e9755;
	localparam logic [31:0] K03 = 32'hb8b34b2b;
	localparam logic [31:0] K04 = 32'ha1e38b95;
	localparam logic [31:0] K05 = 32'hcc9e2d63;
	localparam logic [31:0] K06 = 32'h85ebcacb;
	localparam logic [31:0] K07 = 32'hd56153af;
	localparam logic [31:0] K08 = 32'h942524b1;
	localparam logic [31:0] K09 = 32'ha7a3b46d;
	localparam logic [31:0] K10 = 32'he8293dbb;
	localparam logic [31:0] K11 = 32'h7294d1a7;
	localparam logic [31:0] K12 = 32'h8a5ed6b9;
	localparam logic [31:0] K13 = 32'ha9d1ae7d;
	localparam logic [31:0] K14 = 32'hbd658ba9;
	localparam logic [31:0] K15 = 32'h96d6c7a5;
	localparam logic [31:0] K16 = 32'hb57246b7;

	// register indexes
	localparam logic [1:0] REG_SEED0 = 2'd0;
	localparam logic [1:0] REG_SEED1 = 2'd1;
	localparam logic [1:0] REG_SEED2 = 2'd2;

	typedef struct packed {
		logic [63:0] bytes_lo;
		logic [63:0] bytes_mid_lo;
		logic [63:0] bytes_mid_hi;
		logic [63:0] bytes_hi;
		logic [5:0]  bytes_valid;
		logic        last_item;
	} in_word_t;

	typedef struct packed {
		logic [31:0] hash_low;
		logic [31:0] hash_high;
	} out_word_t;

	// multiplier unit request: one product a cycle
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
	} mul_req_t;

	function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned r);
		logic [63:0] d;
		d = {x, x} << r;
		return d[63:32];
	endfunction

endpackage

// File: rtl/mrh_mul.sv
// ============================================================================
// mrh_mul
// Shared 32x32 multiplier, low 32 bits of the product, registered output.
// ============================================================================
module mrh_mul
	import mrh_pkg::*;
(
	input  logic        clk,
	input  mul_req_t    req,
	output logic [31:0] prod_q
);
	// registered low product
	always_ff @(posedge clk) begin
		prod_q <= 32'(req.a * req.b);
	end
endmodule

// File: rtl/multiply_rotate_hash_64_unit.sv
// ============================================================================
// multiply_rotate_hash_64_unit
// Multiply-rotate hash over 32-byte words using one shared multiplier.
// ============================================================================
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | in_word_t
// out     | out | out_valid/out_ready | out_word_t
// cfg     | in  | APB psel/penable    | seed_word0..2
// A word is accepted in ST_IDLE; the multiplier then takes one product a cycle
// and each product is captured in the next cycle. A full word runs the full
// block mix; a last word runs a tail step (empty or up to 4 bytes, up to 8, 16
// or 32), then finalization, then the load of the result register.
// A full last word adds the empty 4-byte tail. Reset clears the sequencer, mix
// words, data_seen and seeds; in_ready is low while a word is in work or while
// a finished hash waits for the result register to free up.
module multiply_rotate_hash_64_unit
	import mrh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_FILL = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	// micro-op: product = (x) * k; rows of a program selected by step count
	logic [31:0] seed0_q, seed1_q, seed2_q;
	logic [31:0] h1_q, h2_q, h3_q;
	logic        seen_q;
	state_t      st_q;
	in_word_t    it_q;
	logic [5:0]  n_q;
	logic [2:0]  mode_q;   // 0 full,1 mix4 const,2 mix4,3 mix8,4 mix16,5 mix32 tail,6 fin
	logic        last_q;
	logic [4:0]  pc_q;
	logic [31:0] t_q [0:11];
	logic [31:0] w [0:7];
	mul_req_t    req;
	logic [31:0] prod_q;
	logic [31:0] p;
	logic        done;
	out_word_t   out_q;
	logic        out_valid_q;
	logic        out_load;

	localparam logic [2:0] M_FULL = 3'd0, M_C4 = 3'd1, M_4 = 3'd2, M_8 = 3'd3,
		M_16 = 3'd4, M_32 = 3'd5, M_FIN = 3'd6;

	mrh_mul u_mul (.clk(clk), .req(req), .prod_q(prod_q));
	assign p = prod_q;

	// masked words of current item
	always_comb begin
		logic [255:0] raw, msk;
		raw = {it_q.bytes_hi, it_q.bytes_mid_hi, it_q.bytes_mid_lo, it_q.bytes_lo};
		msk = (mode_q == M_FULL) ? {256{1'b1}} : ~({256{1'b1}} << {n_q, 3'b000});
		raw = raw & msk;
		for (int i = 0; i < 8; i++) w[i] = raw[32*i +: 32];
	end

	// program: at each pc issue a multiply; products of a pair combine into t_q.
	// The product issued at pc is captured the next cycle; t_q[10] holds a pair's first product.
	always_comb begin
		req = '{a: 32'd0, b: 32'd0};
		done = 1'b0;
		case (mode_q)
		M_FULL, M_32: begin
			case (pc_q)
			5'd0:  req = '{h3_q ^ w[0], K01};
			5'd1:  req = '{rol(w[1], 16), K05};
			5'd2:  req = '{h3_q ^ w[1], K02};
			5'd3:  req = '{rol(w[2], 16), K06};
			5'd4:  req = '{h2_q ^ w[2], K03};
			5'd5:  req = '{rol(w[3], 16), K07};
			5'd6:  req = '{h2_q ^ w[3], K04};
			5'd7:  req = '{rol(w[4], 16), K08};
			// t0=va t1=vb t2=vc t3=vd
			5'd8:  req = '{w[4] ^ rol(h1_q ^ t_q[0], 15), K09};
			5'd9:  req = '{t_q[2] ^ rol(w[5], 16), K13};
			5'd10: req = '{w[5] ^ rol(t_q[3], 15), K10};
			5'd11: req = '{t_q[0] ^ rol(w[6], 16), K14};
			5'd12: req = '{w[6] ^ rol(t_q[1], 15), K11};
			5'd13: req = '{t_q[3] ^ rol(w[7], 16), K15};
			5'd14: req = '{w[7] ^ rol(h1_q ^ t_q[2], 15), K12};
			5'd15: req = '{t_q[1] ^ rol(w[0], 16), K16};
			// t4=v1 t5=v2 t6=v3 t7=v4
			5'd16: req = '{t_q[6] ^ rol(t_q[4], 15), K06};
			5'd17: req = '{(h3_q ^ t_q[7]) ^ rol(t_q[5], 16), K07};
			5'd19: req = '{t_q[8] ^ rol(t_q[5], 5) ^ rol(t_q[6], 15), K12};
			5'd20: req = '{(h2_q ^ t_q[4]) ^ rol(t_q[7], 16), K16};
			5'd22: req = '{h2_q ^ rol(h3_q, 15), K05};
			5'd23: req = '{h3_q ^ rol(h2_q, 16), K06};
			5'd25: done = 1'b1;
			default: ;
			endcase
		end
		M_16: begin
			case (pc_q)
			5'd0: req = '{h1_q ^ w[0], K01};
			5'd1: req = '{rol(w[1], 16), K05};
			5'd2: req = '{h1_q ^ w[1], K02};
			5'd3: req = '{rol(w[2], 16), K06};
			5'd4: req = '{h2_q ^ w[2], K03};
			5'd5: req = '{rol(w[3], 16), K07};
			5'd6: req = '{h2_q ^ w[3], K04};
			5'd7: req = '{rol(w[0], 16), K08};
			// t0=v1 t1=v2 t2=v3 t3=v4
			5'd8: req = '{t_q[2] ^ rol(t_q[0], 15), K06};
			5'd9: req = '{(h3_q ^ t_q[3]) ^ rol(t_q[1], 16), K07};
			5'd11: req = '{t_q[8] ^ rol(t_q[1], 5) ^ rol(t_q[2], 15), K04};
			5'd12: req = '{(h2_q ^ t_q[0]) ^ rol(t_q[3], 16), K08};
			5'd14: done = 1'b1;
			default: ;
			endcase
		end
		M_8: begin
			case (pc_q)
			5'd0: req = '{h1_q ^ w[0], K01};
			5'd1: req = '{rol(w[1], 16), K03};
			5'd2: req = '{h2_q ^ w[1], K02};
			5'd3: req = '{rol(w[0], 16), K04};
			// t0=v1 t1=v2, v2 lands at the end of pc 4
			5'd5: req = '{(h3_q ^ t_q[0]) ^ rol(t_q[1], 15), K07};
			5'd6: req = '{t_q[1] ^ rol(t_q[0], 16), K08};
			5'd8: req = '{h2_q ^ rol(t_q[0], 15), K01};
			5'd9: req = '{t_q[8] ^ rol(t_q[1], 16), K03};
			5'd11: done = 1'b1;
			default: ;
			endcase
		end
		M_4, M_C4: begin
			case (pc_q)
			5'd0: req = '{h1_q ^ t_q[9], K01};
			5'd1: req = '{h3_q ^ rol(t_q[9], 16), K03};
			5'd3: req = '{h2_q ^ rol(t_q[9], 15), K02};
			5'd4: req = '{t_q[9] ^ rol(t_q[8], 16), K04};
			5'd6: done = 1'b1;
			default: ;
			endcase
		end
		default: begin // finalization
			case (pc_q)
			5'd0: req = '{h1_q ^ rol(~h2_q, 2) ^ rol(h3_q, 15), K11};
			5'd1: req = '{h3_q ^ rol(h2_q, 16), K10};
			5'd3: req = '{h3_q ^ rol(t_q[8], 2) ^ rol(h2_q, 15), K15};
			5'd4: req = '{h2_q ^ rol(t_q[8], 16), K14};
			5'd6: done = 1'b1;
			default: ;
			endcase
		end
		endcase
	end

	// which product is captured: pc-1
	logic [4:0] pm1;
	assign pm1 = pc_q - 5'd1;

	assign in_ready  = (st_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_load  = (st_q == ST_OUT) && (!out_valid_q || out_ready);
	assign pready    = 1'b1;

	// config read mux
	always_comb begin
		case (paddr[3:2])
		REG_SEED0: prdata = seed0_q;
		REG_SEED1: prdata = seed1_q;
		REG_SEED2: prdata = seed2_q;
		default:   prdata = 32'd0;
		endcase
	end

	// seed registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed0_q <= '0; seed1_q <= '0; seed2_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
			REG_SEED0: seed0_q <= pwdata;
			REG_SEED1: seed1_q <= pwdata;
			REG_SEED2: seed2_q <= pwdata;
			default: ;
			endcase
		end
	end

	// tail mode select from count
	function automatic logic [2:0] tail_mode(input logic [5:0] n, input logic seen);
		if (!seen && n == 6'd0) return M_C4;
		if (n <= 6'd4) return M_4;
		if (n <= 6'd8) return M_8;
		if (n <= 6'd16) return M_16;
		return M_32;
	endfunction

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		logic [5:0] nv;
		logic [31:0] a1, a2, a3;
		if (!arst_n) begin
			st_q <= ST_IDLE; seen_q <= 1'b0; pc_q <= '0; mode_q <= M_FIN;
			last_q <= 1'b0; n_q <= '0; it_q <= '0;
			h1_q <= '0; h2_q <= '0; h3_q <= '0;
			for (int i = 0; i < 12; i++) t_q[i] <= '0;
		end else begin
			case (st_q)
			ST_IDLE: if (in_valid) begin
				nv = (in_data.bytes_valid > 6'd32) ? 6'd32 : in_data.bytes_valid;
				if (in_data.last_item || nv == 6'd32) begin
					it_q <= in_data;
					last_q <= in_data.last_item;
					a1 = seen_q ? h1_q : seed0_q;
					a2 = seen_q ? h2_q : seed1_q;
					a3 = seen_q ? h3_q : seed2_q;
					h3_q <= a3;
					pc_q <= '0;
					if (nv == 6'd32) begin
						mode_q <= M_FULL; n_q <= 6'd32; h1_q <= a1 + 32'd32; h2_q <= a2;
					end else begin
						n_q <= nv;
						mode_q <= tail_mode(nv, seen_q);
						if (!seen_q && nv == 6'd0) begin
							h1_q <= a1; h2_q <= a2; t_q[9] <= K01;
						end else begin
							h1_q <= a1 + 32'(nv); h2_q <= a2 - 32'(nv);
							// first tail word, bytes past the count cleared
							t_q[9] <= (nv >= 6'd4) ? in_data.bytes_lo[31:0] :
								in_data.bytes_lo[31:0] &
								~(32'hffffffff << {nv[1:0], 3'b000});
						end
					end
					st_q <= ST_RUN;
				end
			end
			ST_RUN: begin
				pc_q <= done ? 5'd0 : pc_q + 5'd1;
				if (pc_q != 5'd0) begin
					// capture product issued last cycle, combining pairs
					case (mode_q)
					M_FULL, M_32: begin
						if (pm1 < 5'd16 && pm1[0]) t_q[{1'b0, pm1[3:1]}] <= t_q[10] + p;
						else if (pm1 == 5'd17) t_q[8] <= rol(t_q[10] ^ p, 7);
						else if (pm1 == 5'd20) h2_q <= t_q[10] ^ p;
						else if (pm1 == 5'd23) h1_q <= h1_q ^ t_q[10] ^ p;
						else t_q[10] <= p;
						if (pm1 == 5'd18) h3_q <= t_q[8];
						if (pm1 == 5'd21 && mode_q == M_32) begin
							st_q <= ST_FILL; // tail block: skip fold
						end
					end
					M_16: begin
						if (pm1 < 5'd8 && pm1[0]) t_q[{1'b0, pm1[3:1]}] <= t_q[10] + p;
						else if (pm1 == 5'd9) t_q[8] <= rol(t_q[10] ^ p, 7);
						else if (pm1 == 5'd12) h2_q <= t_q[10] ^ p;
						else t_q[10] <= p;
						if (pm1 == 5'd10) h3_q <= t_q[8];
					end
					M_8: begin
						if (pm1 < 5'd4 && pm1[0]) t_q[{1'b0, pm1[3:1]}] <= t_q[10] + p;
						else if (pm1 == 5'd6) t_q[8] <= rol(t_q[10] ^ p, 7);
						else if (pm1 == 5'd9) h2_q <= t_q[10] ^ p;
						else t_q[10] <= p;
						if (pm1 == 5'd7) h3_q <= t_q[8];
					end
					M_4, M_C4: begin
						if (pm1 == 5'd1) t_q[8] <= rol(t_q[10] + p, 7);
						else if (pm1 == 5'd4) h2_q <= t_q[10] ^ p;
						else t_q[10] <= p;
						if (pm1 == 5'd2) h3_q <= t_q[8];
					end
					default: begin
						if (pm1 == 5'd1) begin t_q[8] <= t_q[10] ^ p; h1_q <= t_q[10] ^ p; end
						else if (pm1 == 5'd4) h2_q <= t_q[10] ^ p;
						else t_q[10] <= p;
					end
					endcase
				end
				if (done) begin
					if (mode_q == M_FULL) begin
						seen_q <= 1'b1;
						if (last_q) begin
							n_q <= '0; mode_q <= M_4; t_q[9] <= 32'd0;
						end else st_q <= ST_IDLE;
					end else if (mode_q == M_FIN) begin
						st_q <= ST_OUT; seen_q <= 1'b0;
					end else mode_q <= M_FIN;
				end
			end
			ST_FILL: begin
				// mix32 of tail done: go finalize
				pc_q <= '0; mode_q <= M_FIN; st_q <= ST_RUN;
			end
			ST_OUT: if (out_load) st_q <= ST_IDLE;
			default: st_q <= ST_IDLE;
			endcase
		end
	end

	// result register: loaded when a hash is done and the register is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0; out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_q <= '{hash_low: h1_q, hash_high: h2_q};
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer state stays one-hot
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(st_q))
		else $error("sequencer state not one-hot");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_seen_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT) |-> !seen_q) else $error("data_seen not cleared");
endmodule

// File: tb/sv/multiply_rotate_hash_64_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// multiply_rotate_hash_64_unit_tb
// Drives 32-byte message words into the hash unit and checks each finalized
// hash pair against a predictor that tracks the three mix words, data_seen
// and the seed registers. Covers directed corner cases, seed settings from
// all-zero to all-one, and random message streams with sender gaps and
// receiver stalls.
// ============================================================================
module multiply_rotate_hash_64_unit_tb
	import mrh_pkg::*;
;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_word_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_word_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	multiply_rotate_hash_64_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [31:0] seed_q [3];
	logic [31:0] h1, h2, h3;
	bit          seen;
	out_word_t   hash_q [$];

	int unsigned words_sent, hashes_checked, errors, seed_sets;
	bit          gaps_on, stalls_on;
	int unsigned burst_left;

	// ------------------------------------------------------------------
	// hash arithmetic
	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = {32'd0, a} * {32'd0, b};
		return p[31:0];
	endfunction

	function automatic logic [31:0] rot(input logic [31:0] x, input int unsigned r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic logic [31:0] lane_sum(input logic [31:0] a, b, c, e, d);
		return mul32(a ^ b, c) + mul32(rot(e, 16), d);
	endfunction

	function automatic logic [31:0] lane_sum2(input logic [31:0] a, b, c, e, f, d);
		return mul32(a ^ rot(b, 15), c) + mul32(e ^ rot(f, 16), d);
	endfunction

	function automatic logic [31:0] lane_xor(input logic [31:0] a, b, c, e, f, d);
		return mul32(a ^ rot(b, 15), c) ^ mul32(e ^ rot(f, 16), d);
	endfunction

	function automatic logic [31:0] lane_key(input logic [31:0] k, a, input int unsigned ra,
			input logic [31:0] b, c, e, f, d);
		return mul32(k ^ rot(a, ra) ^ rot(b, 15), c) ^ mul32(e ^ rot(f, 16), d);
	endfunction

	function automatic void mix_32(input logic [31:0] w [8]);
		logic [31:0] va, vb, vc, vd, v1, v2, v3, v4;
		va = lane_sum(h3, w[0], K01, w[1], K05);
		vb = lane_sum(h3, w[1], K02, w[2], K06);
		vc = lane_sum(h2, w[2], K03, w[3], K07);
		vd = lane_sum(h2, w[3], K04, w[4], K08);
		v1 = lane_sum2(w[4], h1 ^ va, K09, vc, w[5], K13);
		v2 = lane_sum2(w[5], vd, K10, va, w[6], K14);
		v3 = lane_sum2(w[6], vb, K11, vd, w[7], K15);
		v4 = lane_sum2(w[7], h1 ^ vc, K12, vb, w[0], K16);
		h3 = rot(lane_xor(v3, v1, K06, h3 ^ v4, v2, K07), 7);
		h2 = lane_key(h3, v2, 5, v3, K12, h2 ^ v1, v4, K16);
	endfunction

	function automatic void mix_16(input logic [31:0] w [8]);
		logic [31:0] v1, v2, v3, v4;
		v1 = lane_sum(h1, w[0], K01, w[1], K05);
		v2 = lane_sum(h1, w[1], K02, w[2], K06);
		v3 = lane_sum(h2, w[2], K03, w[3], K07);
		v4 = lane_sum(h2, w[3], K04, w[0], K08);
		h3 = rot(lane_xor(v3, v1, K06, h3 ^ v4, v2, K07), 7);
		h2 = lane_key(h3, v2, 5, v3, K04, h2 ^ v1, v4, K08);
	endfunction

	function automatic void mix_8(input logic [31:0] w [8]);
		logic [31:0] v1, v2;
		v1 = lane_sum(h1, w[0], K01, w[1], K03);
		v2 = lane_sum(h2, w[1], K02, w[0], K04);
		h3 = rot(lane_xor(h3 ^ v1, v2, K07, v2, v1, K08), 7);
		h2 = lane_xor(h2, v1, K01, h3, v2, K03);
	endfunction

	function automatic void mix_4(input logic [31:0] x);
		h3 = rot(mul32(h1 ^ x, K01) + mul32(h3 ^ rot(x, 16), K03), 7);
		h2 = lane_xor(h2, x, K02, x, h3, K04);
	endfunction

	// advance the predictor by one accepted word; queue a hash when one is due
	function automatic void hash_step(input in_word_t d);
		logic [63:0] q [4];
		logic [31:0] w [8];
		logic [63:0] v;
		int unsigned n, avail;
		out_word_t r;
		q[0] = d.bytes_lo;
		q[1] = d.bytes_mid_lo;
		q[2] = d.bytes_mid_hi;
		q[3] = d.bytes_hi;
		n = (d.bytes_valid > 32) ? 32 : d.bytes_valid;
		if (!d.last_item && n != 32)
			return;
		if (!seen) begin
			h1 = seed_q[0];
			h2 = seed_q[1];
			h3 = seed_q[2];
		end
		if (n == 32) begin
			for (int k = 0; k < 4; k++) begin
				w[2*k]   = q[k][31:0];
				w[2*k+1] = q[k][63:32];
			end
			h1 += 32;
			mix_32(w);
			h1 ^= lane_xor(h2, h3, K05, h3, h2, K06);
			seen = 1'b1;
			if (!d.last_item)
				return;
			n = 0;
		end
		if (!seen && n == 0) begin
			// empty message
			mix_4(K01);
		end else begin
			for (int k = 0; k < 4; k++) begin
				avail = (n > 8*k) ? n - 8*k : 0;
				v = q[k];
				if (avail < 8)
					v &= (64'd1 << (8*avail)) - 64'd1;
				w[2*k]   = v[31:0];
				w[2*k+1] = v[63:32];
			end
			h1 += n;
			h2 -= n;
			if (n <= 4)
				mix_4(w[0]);
			else if (n <= 8)
				mix_8(w);
			else if (n <= 16)
				mix_16(w);
			else
				mix_32(w);
		end
		h1 = lane_key(h1, ~h2, 2, h3, K11, h3, h2, K10);
		h2 = lane_key(h3, h1, 2, h2, K15, h2, h1, K14);
		r.hash_low  = h1;
		r.hash_high = h2;
		hash_q.push_back(r);
		seen = 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// receiver: stall pattern, checked at negedge where both sides are stable
	always @(posedge clk) begin
		if (stalls_on)
			out_ready <= ($urandom_range(0, 3) != 0);
		else
			out_ready <= 1'b1;
	end

	always @(negedge clk) begin
		out_word_t e;
		if (arst_n && out_valid && out_ready) begin
			if (hash_q.size() == 0) begin
				$error("unexpected hash word %h", out_data);
				errors++;
			end else begin
				e = hash_q.pop_front();
				hashes_checked++;
				if (out_data.hash_low !== e.hash_low) begin
					$error("hash_low expected %h actual %h", e.hash_low, out_data.hash_low);
					errors++;
				end
				if (out_data.hash_high !== e.hash_high) begin
					$error("hash_high expected %h actual %h", e.hash_high, out_data.hash_high);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// sender; tasks are entered and left at a rising edge
	task automatic send_word(input in_word_t d);
		bit ok;
		in_valid <= 1'b1;
		in_data  <= d;
		do begin
			@(negedge clk);
			ok = in_ready;
			@(posedge clk);
		end while (!ok);
		hash_step(d);
		words_sent++;
		// burst/gap pacing
		if (gaps_on) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(0, 12);
			end else
				burst_left--;
		end
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic in_word_t make_word(input int unsigned cnt, input bit lst);
		in_word_t d;
		d.bytes_lo     = rand64();
		d.bytes_mid_lo = rand64();
		d.bytes_mid_hi = rand64();
		d.bytes_hi     = rand64();
		d.bytes_valid  = cnt[5:0];
		d.last_item    = lst;
		return d;
	endfunction

	// wait until every hash is back, then let a tail-only item finish
	task automatic drain();
		in_valid <= 1'b0;
		while (hash_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_seed(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		seed_q[idx] = val;
		// bus returns to idle between transfers
		@(posedge clk);
	endtask

	task automatic set_seeds(input logic [31:0] s0, s1, s2);
		drain();
		write_seed(REG_SEED0, s0);
		write_seed(REG_SEED1, s1);
		write_seed(REG_SEED2, s2);
		seed_sets++;
	endtask

	// ------------------------------------------------------------------
	task automatic test_directed();
		in_word_t d;
		int unsigned sizes [8] = '{1, 4, 5, 8, 9, 16, 17, 31};
		gaps_on = 1'b0;
		// empty message
		send_word(make_word(0, 1'b1));
		// tail lengths at each mixing-step boundary, junk past the count
		foreach (sizes[i])
			send_word(make_word(sizes[i], 1'b1));
		// full block then empty tail
		send_word(make_word(32, 1'b0));
		send_word(make_word(0, 1'b1));
		// full last word
		send_word(make_word(32, 1'b1));
		// oversized counts
		send_word(make_word(63, 1'b1));
		send_word(make_word(33, 1'b0));
		send_word(make_word(12, 1'b1));
		// short non-last word is dropped
		send_word(make_word(20, 1'b0));
		send_word(make_word(3, 1'b1));
		// all ones and all zeros payloads
		d = '1;
		d.bytes_valid = 6'd31;
		send_word(d);
		d = '0;
		d.bytes_valid = 6'd32;
		send_word(d);
		d.last_item = 1'b1;
		d.bytes_valid = 6'd24;
		send_word(d);
	endtask

	task automatic test_random_messages(input int unsigned count);
		int unsigned nfull, sel, tail;
		int unsigned sent0;
		sent0 = words_sent;
		while (words_sent - sent0 < count) begin
			// pace changes now and then, including stretches with no gaps
			if ($urandom_range(0, 15) == 0) begin
				gaps_on   = $urandom_range(0, 2) != 0;
				stalls_on = $urandom_range(0, 2) != 0;
			end
			nfull = $urandom_range(0, 3);
			for (int i = 0; i < nfull; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_word(make_word($urandom_range(0, 31), 1'b0));
				sel = $urandom_range(0, 19);
				send_word(make_word((sel == 0) ? $urandom_range(33, 63) : 32, 1'b0));
			end
			sel = $urandom_range(0, 19);
			if (sel < 3)
				tail = 32;
			else if (sel == 3)
				tail = $urandom_range(33, 63);
			else
				tail = $urandom_range(0, 31);
			send_word(make_word(tail, 1'b1));
		end
	endtask

	task automatic test_seed_settings();
		set_seeds('0, '0, '1);
		test_random_messages(300);
		set_seeds('1, '1, '1);
		test_directed();
		test_random_messages(300);
		set_seeds($urandom, $urandom, $urandom);
		test_random_messages(300);
	endtask

	// ------------------------------------------------------------------
	initial begin
		seed_q = '{default: '0};
		h1 = '0;
		h2 = '0;
		h3 = '0;
		seen = 1'b0;
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		burst_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		test_random_messages(600);
		test_seed_settings();
		set_seeds('0, '0, '0);
		test_random_messages(300);
		drain();

		$display("covered %0d words, %0d hashes checked, %0d seed settings",
			words_sent, hashes_checked, seed_sets);
		$display("tail sizes 0..31, full and oversized counts, dropped short words");
		if (errors == 0)
			$display("multiply_rotate_hash_64_unit_tb passed");
		else
			$display("multiply_rotate_hash_64_unit_tb failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("multiply_rotate_hash_64_unit_tb failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/mrh_pkg.sv
rtl/mrh_mul.sv
rtl/multiply_rotate_hash_64_unit.sv
tb/sv/multiply_rotate_hash_64_unit_tb.sv
